// File: hw/rtl/bae_pkg.sv
`default_nettype none

package bae_pkg;

    // Arena and table dimensions.
    localparam int unsigned ARENA_BYTES = 65536;
    localparam int unsigned MAX_CHUNKS  = 64;

    // Widths of the request and response fields.
    localparam int unsigned OFF_W  = 16;
    localparam int unsigned SIZE_W = 17;
    localparam int unsigned ST_W   = 3;

    // Widths that follow from the dimensions.
    localparam int unsigned IDX_W  = $clog2(MAX_CHUNKS);
    localparam int unsigned CNT_W  = IDX_W + 1;
    localparam int unsigned CUR_W  = $clog2(ARENA_BYTES) + 1;
    localparam int unsigned SUM_W  = ((CUR_W > SIZE_W) ? CUR_W : SIZE_W) + 1;
    localparam int unsigned DATA_W = OFF_W + SIZE_W + 1;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes.
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic advance;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: hw/rtl/bae_ram.sv
`default_nettype none

module bae_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bae_ctrl.sv
`default_nettype none

module bae_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bae_pkg::t_sts i_sts,
    output bae_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // A new request is taken only between scans.
    assign o_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd.start   = 1'b0;
        o_cmd.advance = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_sts.done) begin
                    o_cmd.advance = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bae_dp.sv
`default_nettype none

module bae_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_operation,
    input  wire logic [bae_pkg::SIZE_W-1:0]    i_request_size,
    input  wire logic [bae_pkg::OFF_W-1:0]     i_free_offset,
    input  wire bae_pkg::t_cmd                 i_cmd,
    output bae_pkg::t_sts                      o_sts,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [bae_pkg::ST_W-1:0]      o_status,
    output logic      [bae_pkg::OFF_W-1:0]     o_chunk_offset
);

    // Latched request.
    logic                          r_op;
    logic [bae_pkg::SIZE_W-1:0]    r_size;
    logic [bae_pkg::OFF_W-1:0]     r_foff;

    // Table bookkeeping and scan position.
    logic [bae_pkg::CNT_W-1:0]     r_count;
    logic [bae_pkg::CUR_W-1:0]     r_cursor;
    logic [bae_pkg::CNT_W-1:0]     r_rd_idx;
    logic [bae_pkg::IDX_W-1:0]     r_chk_idx;
    logic                          r_chk_vld;

    // Response register.
    logic                          r_out_vld;
    logic [bae_pkg::ST_W-1:0]      r_out_st;
    logic [bae_pkg::OFF_W-1:0]     r_out_off;

    // Table memory ports.
    logic                          wr_en;
    logic [bae_pkg::IDX_W-1:0]     wr_addr;
    logic [bae_pkg::DATA_W-1:0]    wr_data;
    logic [bae_pkg::DATA_W-1:0]    rd_data;

    // Decoded entry and decision terms.
    logic [bae_pkg::OFF_W-1:0]     rd_off;
    logic [bae_pkg::SIZE_W-1:0]    rd_size;
    logic                          rd_free;
    logic                          is_alloc;
    logic                          zero;
    logic                          match;
    logic                          hit;
    logic                          scan_end;
    logic [bae_pkg::SUM_W-1:0]     sum;
    logic                          no_space;
    logic                          full;
    logic                          bump;
    logic [bae_pkg::ST_W-1:0]      res_st;
    logic [bae_pkg::OFF_W-1:0]     res_off;
    logic                          res_wr;

    bae_ram #(
        .WIDTH (bae_pkg::DATA_W),
        .DEPTH (bae_pkg::MAX_CHUNKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.advance),
        .i_rd_addr (r_rd_idx[bae_pkg::IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Entry fields: offset on top, then size, then the free mark.
    assign rd_off  = rd_data[bae_pkg::DATA_W-1 -: bae_pkg::OFF_W];
    assign rd_size = rd_data[bae_pkg::SIZE_W:1];
    assign rd_free = rd_data[0];

    // Match the entry from the last table read and check for space at the cursor.
    always_comb begin
        is_alloc = (r_op == bae_pkg::OP_ALLOC);
        zero     = is_alloc && (r_size == '0);
        match    = is_alloc ? (rd_free && (rd_size == r_size)) : (rd_off == r_foff);
        hit      = r_chk_vld && match;
        scan_end = (r_rd_idx == r_count);
        sum      = bae_pkg::SUM_W'(r_cursor) + bae_pkg::SUM_W'(r_size);
        no_space = (sum > bae_pkg::SUM_W'(bae_pkg::ARENA_BYTES));
        full     = (r_count >= bae_pkg::CNT_W'(bae_pkg::MAX_CHUNKS));
    end

    // Outcome of the request once the scan has settled.
    always_comb begin
        res_st  = bae_pkg::ST_OK;
        res_off = '0;
        res_wr  = 1'b0;
        bump    = 1'b0;
        wr_addr = r_chk_idx;
        wr_data = {rd_off, rd_size, !is_alloc};
        if (zero) begin
            res_st = bae_pkg::ST_ZERO;
        end else if (hit) begin
            res_wr = 1'b1;
            if (is_alloc) begin
                res_off = rd_off;
            end
        end else if (!is_alloc) begin
            res_st = bae_pkg::ST_UNKNOWN;
        end else if (no_space) begin
            res_st = bae_pkg::ST_NOSPACE;
        end else if (full) begin
            res_st = bae_pkg::ST_FULL;
        end else begin
            res_wr  = 1'b1;
            bump    = 1'b1;
            res_off = r_cursor[bae_pkg::OFF_W-1:0];
            wr_addr = r_count[bae_pkg::IDX_W-1:0];
            wr_data = {r_cursor[bae_pkg::OFF_W-1:0], r_size, 1'b0};
        end
    end

    assign wr_en = i_cmd.commit && res_wr;

    assign o_sts.done     = zero || hit || scan_end;
    assign o_sts.out_free = !r_out_vld || i_ready;

    // Request latch and scan pointers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_operation;
            r_size <= i_request_size;
            r_foff <= i_free_offset;
        end
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_chk_idx <= '0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.start) begin
            r_rd_idx  <= '0;
            r_chk_vld <= 1'b0;
        end else if (i_cmd.advance) begin
            r_chk_idx <= r_rd_idx[bae_pkg::IDX_W-1:0];
            r_chk_vld <= 1'b1;
            r_rd_idx  <= r_rd_idx + 1'b1;
        end
    end

    // Chunk count and bump cursor advance on a fresh carve.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else if (i_cmd.commit && bump) begin
            r_count  <= r_count + 1'b1;
            r_cursor <= r_cursor + bae_pkg::CUR_W'(r_size);
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_out_st  <= res_st;
            r_out_off <= res_off;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_out_st;
    assign o_chunk_offset = r_out_off;

endmodule

`default_nettype wire

// File: hw/rtl/bump_allocator_exact_reuse.sv
`default_nettype none

// Bump allocator with exact-size reuse over a 64 KiB arena. Each request is
// either an allocate (size in bytes) or a free (arena offset), and gives one
// response carrying a status and, for a successful allocate, the chunk
// offset. Chunks live in a 64-entry single-port-read table that is scanned
// in creation order, one entry per cycle, so a request occupies the block
// for a scan over the N chunks carved so far (a zero-size allocate does not
// scan). The scan stops early at the first matching entry. The response is
// registered when the outcome is committed. A new request is taken while the
// previous response is still waiting at the output, but its outcome is held
// back until that response is taken.
module bump_allocator_exact_reuse (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_operation,
    input  wire logic [bae_pkg::SIZE_W-1:0] i_request_size,
    input  wire logic [bae_pkg::OFF_W-1:0]  i_free_offset,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [bae_pkg::ST_W-1:0]   o_status,
    output logic      [bae_pkg::OFF_W-1:0]  o_chunk_offset
);

    bae_pkg::t_cmd cmd;
    bae_pkg::t_sts sts;

    // Sequencer for accept, scan and commit.
    bae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Chunk table, cursor and response register.
    bae_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_operation    (i_operation),
        .i_request_size (i_request_size),
        .i_free_offset  (i_free_offset),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_chunk_offset (o_chunk_offset)
    );

endmodule

`default_nettype wire
